>>> sv/tmprof_pkg.sv
// Shared types and constants for the trapezoidal motion profile core.
`default_nettype none

package tmprof_pkg;

  // Field widths of the programming model.
  localparam int unsigned PosW  = 48;
  localparam int unsigned VelW  = 40;
  localparam int unsigned MagW  = 39;
  localparam int unsigned DtW   = 32;
  localparam int unsigned PrecW = 32;
  localparam int unsigned OpW   = 2;

  // Shared arithmetic unit sizes.
  localparam int unsigned DvdW      = 80;
  localparam int unsigned DvsW      = 48;
  localparam int unsigned McandW    = 72;
  localparam int unsigned MplrW     = 40;
  localparam int unsigned ProdW     = McandW + MplrW;
  localparam int unsigned CntW      = 7;
  localparam int unsigned MulSteps  = MplrW;
  localparam int unsigned DivSteps  = DvdW;

  // Configuration port.
  localparam int unsigned AddrW = 6;
  localparam int unsigned DataW = 64;

  // Operation codes of an input beat.
  localparam logic [OpW-1:0] OpTick   = 2'd0;
  localparam logic [OpW-1:0] OpStart  = 2'd1;
  localparam logic [OpW-1:0] OpResume = 2'd2;
  localparam logic [OpW-1:0] OpStop   = 2'd3;

  // Register indexes.
  localparam logic [2:0] RegMode   = 3'd0;
  localparam logic [2:0] RegStart  = 3'd1;
  localparam logic [2:0] RegTarget = 3'd2;
  localparam logic [2:0] RegMaxVel = 3'd3;
  localparam logic [2:0] RegAccel  = 3'd4;
  localparam logic [2:0] RegPrec   = 3'd5;
  localparam logic [2:0] RegDir    = 3'd6;

  // Mode register codes.
  localparam logic ModePosition = 1'b0;
  localparam logic ModeVelocity = 1'b1;

  typedef enum logic {
    AluMul = 1'b0,
    AluDiv = 1'b1
  } alu_kind_e;

  typedef struct packed {
    logic      go;
    alu_kind_e kind;
  } alu_req_t;

endpackage

`default_nettype wire

>>> sv/tmprof_alu.sv
// Shared shift-add multiplier and restoring divider, one bit per cycle.
`default_nettype none

module tmprof_alu (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tmprof_pkg::alu_req_t                req_i,
  input  logic [tmprof_pkg::DvdW-1:0]         a_i,
  input  logic [tmprof_pkg::DvsW-1:0]         b_i,
  output logic                                done_o,
  output logic [tmprof_pkg::ProdW-1:0]        res_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  tmprof_pkg::alu_kind_e             kind_q, kind_d;
  logic [tmprof_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic [tmprof_pkg::ProdW-1:0]      p_q, p_d;
  logic [tmprof_pkg::McandW-1:0]     b_q, b_d;
  logic [tmprof_pkg::DvsW-1:0]       rem_q, rem_d;
  logic [tmprof_pkg::McandW:0]       sum;
  logic [tmprof_pkg::DvsW:0]         rs;
  logic [tmprof_pkg::DvsW:0]         rsub;
  logic                              ge;

  // One iteration of either operation, plus the load of a new request.
  always_comb begin
    sum  = {1'b0, p_q[tmprof_pkg::ProdW-1:tmprof_pkg::MplrW]}
         + (p_q[0] ? {1'b0, b_q} : '0);
    rs   = {rem_q, p_q[tmprof_pkg::DvdW-1]};
    ge   = rs >= {1'b0, b_q[tmprof_pkg::DvsW-1:0]};
    rsub = rs - {1'b0, b_q[tmprof_pkg::DvsW-1:0]};

    busy_d = busy_q;
    done_d = 1'b0;
    kind_d = kind_q;
    cnt_d  = cnt_q;
    p_d    = p_q;
    b_d    = b_q;
    rem_d  = rem_q;

    if (req_i.go) begin
      busy_d = 1'b1;
      kind_d = req_i.kind;
      rem_d  = '0;
      if (req_i.kind == tmprof_pkg::AluMul) begin
        p_d   = {{tmprof_pkg::McandW{1'b0}}, b_i[tmprof_pkg::MplrW-1:0]};
        b_d   = a_i[tmprof_pkg::McandW-1:0];
        cnt_d = tmprof_pkg::CntW'(tmprof_pkg::MulSteps - 1);
      end else begin
        p_d   = {{(tmprof_pkg::ProdW-tmprof_pkg::DvdW){1'b0}}, a_i};
        b_d   = {{(tmprof_pkg::McandW-tmprof_pkg::DvsW){1'b0}}, b_i};
        cnt_d = tmprof_pkg::CntW'(tmprof_pkg::DivSteps - 1);
      end
    end else if (busy_q) begin
      if (kind_q == tmprof_pkg::AluMul) begin
        p_d = {sum, p_q[tmprof_pkg::MplrW-1:1]};
      end else begin
        p_d   = {p_q[tmprof_pkg::ProdW-1:tmprof_pkg::DvdW],
                 p_q[tmprof_pkg::DvdW-2:0], ge};
        rem_d = ge ? rsub[tmprof_pkg::DvsW-1:0] : rs[tmprof_pkg::DvsW-1:0];
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      kind_q <= tmprof_pkg::AluMul;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      kind_q <= kind_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    b_q   <= b_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign res_o  = p_q;

endmodule

`default_nettype wire

>>> sv/trapezoidal_motion_profile_core.sv
// Top level of the trapezoidal motion profile core: registers and sequencer.
//
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    op_i, dt_i, real_position_i, check_real_i
// out      output     out_valid_o / out_stall_i  position_o, velocity_o, finished_o
// cfg      input      psel, penable, pwrite      paddr, pwdata, prdata (8 bytes a register)
//
// Start, resume and stop beats go from idle straight to the output state. A
// tick runs on one shared bit-serial unit. A braking tick needs four multiplies
// and two divides, a move from rest one divide and two multiplies, a velocity-mode
// ramp two multiplies and a position-mode ramp four multiplies and one divide;
// a real-position retry runs the tick a second time.
// Reset is asynchronous and active low. A stalled result holds in the output
// register; the next beat is accepted meanwhile and waits there at its end.
`default_nettype none

module trapezoidal_motion_profile_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [tmprof_pkg::OpW-1:0]            op_i,
  input  logic [tmprof_pkg::DtW-1:0]            dt_i,
  input  logic signed [tmprof_pkg::PosW-1:0]    real_position_i,
  input  logic                                  check_real_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [tmprof_pkg::PosW-1:0]    position_o,
  output logic signed [tmprof_pkg::VelW-1:0]    velocity_o,
  output logic                                  finished_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tmprof_pkg::AddrW-1:0]          paddr,
  input  logic [tmprof_pkg::DataW-1:0]          pwdata,
  output logic [tmprof_pkg::DataW-1:0]          prdata,
  output logic                                  pready
);

  typedef enum logic [13:0] {
    StIdle  = 14'b00000000000001,
    StTick  = 14'b00000000000010,
    StEval  = 14'b00000000000100,
    StNDiv  = 14'b00000000001000,
    StNMul  = 14'b00000000010000,
    StBW    = 14'b00000000100000,
    StBSq   = 14'b00000001000000,
    StBLim  = 14'b00000010000000,
    StBX    = 14'b00000100000000,
    StBDv   = 14'b00001000000000,
    StRamp  = 14'b00010000000000,
    StAdv   = 14'b00100000000000,
    StCheck = 14'b01000000000000,
    StOut   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic        mode_q;
  logic [47:0] start_q;
  logic [47:0] tgt_q;
  logic [38:0] vmax_q;
  logic [38:0] accel_q;
  logic [31:0] prec_q;
  logic        dir_q;

  // Motion state and per-tick working registers.
  logic [47:0] pos_q, pos_d;
  logic [39:0] vel_q, vel_d;
  logic        done_q, done_d;
  logic        stop_q, stop_d;
  logic [39:0] v0_q, v0_d;
  logic [39:0] pv_q, pv_d;
  logic        pd_q, pd_d;
  logic        retick_q, retick_d;
  logic [79:0] q_q, q_d;
  logic [71:0] w_q, w_d;
  logic [31:0] dt_q, dt_d;
  logic [47:0] real_q, real_d;
  logic        chk_q, chk_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [47:0] out_pos_q, out_pos_d;
  logic [39:0] out_vel_q, out_vel_d;
  logic        out_fin_q, out_fin_d;

  // Shared unit.
  tmprof_pkg::alu_req_t alu_req;
  logic [79:0]          alu_a;
  logic [47:0]          alu_b;
  logic                 alu_done;
  logic [111:0]         alu_res;

  // Combinational helpers.
  logic [48:0]        diff;
  logic [47:0]        tgt_dist;
  logic               fwd;
  logic [39:0]        av;
  logic [48:0]        rdiff;
  logic [47:0]        rdist;
  logic signed [40:0] vs;
  logic [40:0]        vs_abs;
  logic signed [40:0] v41;
  logic signed [40:0] nv;
  logic signed [40:0] goal;
  logic [79:0]        m80;
  logic [80:0]        lim;
  logic signed [49:0] np;
  logic [39:0]        dstep;
  logic               wr;

  tmprof_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  // Register writes and reads.
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      start_q <= '0;
      tgt_q   <= '0;
      vmax_q  <= '0;
      accel_q <= '0;
      prec_q  <= '0;
      dir_q   <= 1'b0;
    end else if (wr) begin
      case (paddr[5:3])
        tmprof_pkg::RegMode:   mode_q  <= pwdata[0];
        tmprof_pkg::RegStart:  start_q <= pwdata[47:0];
        tmprof_pkg::RegTarget: tgt_q   <= pwdata[47:0];
        tmprof_pkg::RegMaxVel: vmax_q  <= pwdata[38:0];
        tmprof_pkg::RegAccel:  accel_q <= pwdata[38:0];
        tmprof_pkg::RegPrec:   prec_q  <= pwdata[31:0];
        tmprof_pkg::RegDir:    dir_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      tmprof_pkg::RegMode:   prdata = {63'd0, mode_q};
      tmprof_pkg::RegStart:  prdata = {16'd0, start_q};
      tmprof_pkg::RegTarget: prdata = {16'd0, tgt_q};
      tmprof_pkg::RegMaxVel: prdata = {25'd0, vmax_q};
      tmprof_pkg::RegAccel:  prdata = {25'd0, accel_q};
      tmprof_pkg::RegPrec:   prdata = {32'd0, prec_q};
      tmprof_pkg::RegDir:    prdata = {63'd0, dir_q};
      default:               prdata = '0;
    endcase
  end

  // Distances and magnitudes taken from the registered state.
  always_comb begin
    diff     = {tgt_q[47], tgt_q} - {pos_q[47], pos_q};
    fwd      = !diff[48];
    tgt_dist = fwd ? diff[47:0] : 48'(49'd0 - diff);
    rdiff    = {real_q[47], real_q} - {tgt_q[47], tgt_q};
    rdist    = rdiff[48] ? 48'(49'd0 - rdiff) : rdiff[47:0];
    av       = v0_q[39] ? (40'd0 - v0_q) : v0_q;
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    vel_d       = vel_q;
    done_d      = done_q;
    stop_d      = stop_q;
    v0_d        = v0_q;
    pv_d        = pv_q;
    pd_d        = pd_q;
    retick_d    = retick_q;
    q_d         = q_q;
    w_d         = w_q;
    dt_d        = dt_q;
    real_d      = real_q;
    chk_d       = chk_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_pos_d   = out_pos_q;
    out_vel_d   = out_vel_q;
    out_fin_d   = out_fin_q;
    alu_req     = '{go: 1'b0, kind: tmprof_pkg::AluMul};
    alu_a       = '0;
    alu_b       = '0;
    vs          = '0;
    vs_abs      = '0;
    v41         = $signed({v0_q[39], v0_q});
    nv          = '0;
    goal        = '0;
    m80         = '0;
    lim         = '0;
    np          = '0;
    dstep       = '0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          case (op_i)
            tmprof_pkg::OpStart: begin
              pos_d   = start_q;
              vel_d   = '0;
              done_d  = 1'b0;
              stop_d  = 1'b0;
              state_d = StOut;
            end
            tmprof_pkg::OpResume: begin
              done_d  = 1'b0;
              stop_d  = 1'b0;
              state_d = StOut;
            end
            tmprof_pkg::OpStop: begin
              stop_d  = 1'b1;
              state_d = StOut;
            end
            default: begin
              dt_d     = dt_i;
              real_d   = real_position_i;
              chk_d    = check_real_i;
              pv_d     = vel_q;
              pd_d     = done_q;
              retick_d = 1'b0;
              state_d  = StTick;
            end
          endcase
        end
      end

      // Snapshot the velocity and pick the kind of tick.
      StTick: begin
        v0_d = vel_q;
        if (done_q) begin
          state_d = StCheck;
        end else if (mode_q == tmprof_pkg::ModeVelocity) begin
          alu_req = '{go: 1'b1, kind: tmprof_pkg::AluMul};
          alu_a   = {41'd0, accel_q};
          alu_b   = {16'd0, dt_q};
          state_d = StRamp;
        end else begin
          state_d = StEval;
        end
      end

      // Arrival window, move from rest, or moving.
      StEval: begin
        if (tgt_dist < {16'd0, prec_q}) begin
          pos_d   = tgt_q;
          vel_d   = '0;
          done_d  = 1'b1;
          state_d = StCheck;
        end else if (av == '0) begin
          alu_req = '{go: 1'b1, kind: tmprof_pkg::AluDiv};
          alu_a   = {tgt_dist, 32'd0};
          alu_b   = {16'd0, dt_q};
          state_d = StNDiv;
        end else begin
          alu_req = '{go: 1'b1, kind: tmprof_pkg::AluMul};
          alu_a   = {40'd0, av};
          alu_b   = {16'd0, dt_q};
          state_d = StBW;
        end
      end

      StNDiv: begin
        if (alu_done) begin
          q_d     = alu_res[79:0];
          alu_req = '{go: 1'b1, kind: tmprof_pkg::AluMul};
          alu_a   = {41'd0, accel_q};
          alu_b   = {16'd0, dt_q};
          state_d = StNMul;
        end
      end

      // Nudge speed is the least of distance/dt, a*dt and the cruise speed.
      StNMul: begin
        if (alu_done) begin
          m80 = q_q;
          if ({41'd0, alu_res[70:32]} < m80) begin
            m80 = {41'd0, alu_res[70:32]};
          end
          if ({41'd0, vmax_q} < m80) begin
            m80 = {41'd0, vmax_q};
          end
          nv      = fwd ? $signed({2'b00, m80[38:0]}) : $signed(41'd0 - {2'b00, m80[38:0]});
          vel_d   = nv[39:0];
          vs      = nv;
          vs_abs  = vs[40] ? 41'(41'd0 - vs) : vs;
          alu_req = '{go: 1'b1, kind: tmprof_pkg::AluMul};
          alu_a   = {39'd0, vs_abs};
          alu_b   = {16'd0, dt_q};
          state_d = StAdv;
        end
      end

      StBW: begin
        if (alu_done) begin
          w_d     = alu_res[71:0];
          alu_req = '{go: 1'b1, kind: tmprof_pkg::AluMul};
          alu_a   = {40'd0, av};
          alu_b   = {8'd0, av};
          state_d = StBSq;
        end
      end

      // Stopping distance v*v/(2a).
      StBSq: begin
        if (alu_done) begin
          alu_req = '{go: 1'b1, kind: tmprof_pkg::AluDiv};
          alu_a   = alu_res[79:0];
          alu_b   = {8'd0, accel_q, 1'b0};
          state_d = StBLim;
        end
      end

      // Lookahead decides between braking, snapping to the target and ramping; a stop always brakes.
      StBLim: begin
        if (alu_done) begin
          lim = {1'b0, alu_res[79:0]} + {41'd0, w_q[71:32]};
          if (stop_q || ({33'd0, tgt_dist} <= lim)) begin
            if ({tgt_dist, 33'd0} <= {9'd0, w_q}) begin
              pos_d   = tgt_q;
              vel_d   = '0;
              done_d  = 1'b1;
              state_d = StCheck;
            end else begin
              alu_req = '{go: 1'b1, kind: tmprof_pkg::AluMul};
              alu_a   = {8'd0, w_q};
              alu_b   = {8'd0, av};
              state_d = StBX;
            end
          end else begin
            alu_req = '{go: 1'b1, kind: tmprof_pkg::AluMul};
            alu_a   = {41'd0, accel_q};
            alu_b   = {16'd0, dt_q};
            state_d = StRamp;
          end
        end
      end

      StBX: begin
        if (alu_done) begin
          alu_req = '{go: 1'b1, kind: tmprof_pkg::AluDiv};
          alu_a   = {1'b0, alu_res[111:33]};
          alu_b   = tgt_dist;
          state_d = StBDv;
        end
      end

      // Adapted braking step, never past zero.
      StBDv: begin
        if (alu_done) begin
          if (v41 > $signed(41'd0)) begin
            nv = v41 - $signed({1'b0, alu_res[39:0]});
            if (nv < $signed(41'd0)) begin
              nv = '0;
            end
          end else begin
            nv = v41 + $signed({1'b0, alu_res[39:0]});
            if (nv > $signed(41'd0)) begin
              nv = '0;
            end
          end
          vel_d   = nv[39:0];
          vs      = v41 + nv;
          vs_abs  = vs[40] ? 41'(41'd0 - vs) : vs;
          alu_req = '{go: 1'b1, kind: tmprof_pkg::AluMul};
          alu_a   = {39'd0, vs_abs};
          alu_b   = {16'd0, dt_q};
          state_d = StAdv;
        end
      end

      // Ramp toward the goal speed by a*dt.
      StRamp: begin
        if (alu_done) begin
          if (mode_q == tmprof_pkg::ModeVelocity) begin
            if (stop_q) begin
              goal = '0;
            end else begin
              goal = dir_q ? $signed(41'd0 - {2'b00, vmax_q}) : $signed({2'b00, vmax_q});
            end
          end else begin
            goal = fwd ? $signed({2'b00, vmax_q}) : $signed(41'd0 - {2'b00, vmax_q});
          end
          nv = v41;
          if (v41 < goal) begin
            nv = v41 + $signed({2'b00, alu_res[70:32]});
            if (nv > goal) begin
              nv = goal;
            end
          end else if (v41 > goal) begin
            nv = v41 - $signed({2'b00, alu_res[70:32]});
            if (nv < goal) begin
              nv = goal;
            end
          end
          vel_d = nv[39:0];
          if (mode_q == tmprof_pkg::ModeVelocity && stop_q && nv == '0) begin
            done_d = 1'b1;
          end
          vs      = v41 + nv;
          vs_abs  = vs[40] ? 41'(41'd0 - vs) : vs;
          alu_req = '{go: 1'b1, kind: tmprof_pkg::AluMul};
          alu_a   = {39'd0, vs_abs};
          alu_b   = {16'd0, dt_q};
          state_d = StAdv;
        end
      end

      // Position moves by the mean speed times dt, saturating.
      StAdv: begin
        if (alu_done) begin
          dstep = alu_res[72:33];
          vs    = v41 + $signed({vel_q[39], vel_q});
          if (!vs[40]) begin
            np = $signed({{2{pos_q[47]}}, pos_q}) + $signed({10'd0, dstep});
          end else begin
            np = $signed({{2{pos_q[47]}}, pos_q}) - $signed({10'd0, dstep});
          end
          if (np > $signed({3'b000, {47{1'b1}}})) begin
            pos_d = {1'b0, {47{1'b1}}};
          end else if (np < $signed({3'b111, 47'd0})) begin
            pos_d = {1'b1, 47'd0};
          end else begin
            pos_d = np[47:0];
          end
          state_d = StCheck;
        end
      end

      // Finished but off target by the measured position: retry once from there.
      StCheck: begin
        if (!retick_q && chk_q && done_q && mode_q == tmprof_pkg::ModePosition &&
            rdist > {16'd0, prec_q}) begin
          vel_d    = pv_q;
          done_d   = pd_q;
          pos_d    = real_q;
          retick_d = 1'b1;
          state_d  = StTick;
        end else begin
          state_d = StOut;
        end
      end

      StOut: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_pos_d   = pos_q;
          out_vel_d   = vel_q;
          out_fin_d   = done_q;
          state_d     = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pos_q       <= '0;
      vel_q       <= '0;
      done_q      <= 1'b1;
      stop_q      <= 1'b0;
      retick_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
      done_q      <= done_d;
      stop_q      <= stop_d;
      retick_q    <= retick_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    v0_q      <= v0_d;
    pv_q      <= pv_d;
    pd_q      <= pd_d;
    q_q       <= q_d;
    w_q       <= w_d;
    dt_q      <= dt_d;
    real_q    <= real_d;
    chk_q     <= chk_d;
    out_pos_q <= out_pos_d;
    out_vel_q <= out_vel_d;
    out_fin_q <= out_fin_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign position_o  = out_pos_q;
  assign velocity_o  = out_vel_q;
  assign finished_o  = out_fin_q;

endmodule

`default_nettype wire
